// ===== design/sdmg_pkg.sv =====
// ----------------------------------------------------------------------------
// sdmg_pkg : shared types and constants for the step/direction move generator
// Holds the queue geometry, the queued command layout, the sequencer status
// bundle and the reciprocal used to divide the pulse product by 100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdmg_pkg;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int HP_W    = 8;
    localparam int SPD_W   = 12;
    localparam int PULSE_W = 22;
    localparam int POS_W   = 32;
    localparam int PROD_W  = ANGLE_W + SPD_W;

    // Configuration register indexes
    localparam logic CFG_STEPS_PER_DEGREE = 1'b0;
    localparam logic CFG_MIN_HALF_PERIOD  = 1'b1;

    localparam logic [SPD_W-1:0] SPD_RESET = SPD_W'(700);
    localparam logic [HP_W-1:0]  MHP_RESET = HP_W'(8);

    localparam logic [7:0] HEADER_CMD = 8'd1;

    // Input kind carried in tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_CMD  = 1'b1;

    // floor(p / 100) = (p * RECIP_100) >> RECIP_SHIFT, exact for p < 2**30
    localparam int              RECIP_SHIFT = 35;
    localparam int              RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(343597384);
    localparam int              QPROD_W     = PROD_W + RECIP_W;

    localparam int SMALL_LIMIT = 100;

    typedef struct packed {
        logic [HP_W-1:0]    half_period;
        logic               dir;
        logic [ANGLE_W-1:0] angle;
    } cmd_t;

    typedef struct packed {
        logic             pulse;
        logic             sign;
        logic             busy;
        logic [POS_W-1:0] position;
        logic [31:0]      started;
    } seq_status_t;

endpackage

`default_nettype wire

// ===== design/sdmg_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// sdmg_cmd_fifo : command queue
// Circular buffer in a memory with registered read; the head entry is
// prefetched so it is ready on the cycle it is popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdmg_cmd_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire sdmg_pkg::cmd_t        wr_data,
    input  wire logic                  rd_en,
    output sdmg_pkg::cmd_t             head_data,
    output logic                       not_empty,
    output logic                       full
);

    sdmg_pkg::cmd_t mem [sdmg_pkg::QUEUE_DEPTH];

    logic [sdmg_pkg::PTR_W-1:0] head_reg, head_next;
    logic [sdmg_pkg::PTR_W-1:0] tail_reg, tail_next;
    logic [sdmg_pkg::CNT_W-1:0] count_reg, count_next;
    sdmg_pkg::cmd_t             rd_data_reg;

    localparam logic [sdmg_pkg::PTR_W-1:0] LAST_PTR =
        sdmg_pkg::PTR_W'(sdmg_pkg::QUEUE_DEPTH - 1);
    localparam logic [sdmg_pkg::CNT_W-1:0] FULL_CNT =
        sdmg_pkg::CNT_W'(sdmg_pkg::QUEUE_DEPTH);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (wr_en) begin
            tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
        end
        if (rd_en) begin
            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        end
        // Hold the count when a push and a pop meet
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Write port; read the next head, forwarding a same-cycle write to it
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= wr_data;
        end
        if (wr_en && (tail_reg == head_next)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[head_next];
        end
    end

    assign head_data = rd_data_reg;
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FULL_CNT);

endmodule

`default_nettype wire

// ===== design/sdmg_pulse_count.sv =====
// ----------------------------------------------------------------------------
// sdmg_pulse_count : pulse count for a new move
// Two-stage product: angle * steps_per_degree, then division by 100 through
// a reciprocal multiply. Result is valid in the cycle after launch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdmg_pulse_count (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          launch,
    input  wire logic [sdmg_pkg::ANGLE_W-1:0]  angle,
    input  wire logic [sdmg_pkg::SPD_W-1:0]    steps_per_degree,
    output logic                               count_valid,
    output logic [sdmg_pkg::PULSE_W-1:0]       count
);

    logic [sdmg_pkg::PROD_W-1:0]  prod_reg;
    logic                         valid_reg;
    logic [sdmg_pkg::QPROD_W-1:0] qprod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= launch;
        end
    end

    always_ff @(posedge aclk) begin
        if (launch) begin
            prod_reg <= sdmg_pkg::PROD_W'(angle) * sdmg_pkg::PROD_W'(steps_per_degree);
        end
    end

    assign qprod       = sdmg_pkg::QPROD_W'(prod_reg) * sdmg_pkg::QPROD_W'(sdmg_pkg::RECIP_100);
    assign count       = qprod[sdmg_pkg::RECIP_SHIFT +: sdmg_pkg::PULSE_W];
    assign count_valid = valid_reg;

endmodule

`default_nettype wire

// ===== design/sdmg_step_seq.sv =====
// ----------------------------------------------------------------------------
// sdmg_step_seq : move sequencer
// Pops commands on ticks, times the step pulses, tracks position and the
// started-move count. Presents the post-tick status for the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdmg_step_seq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        tick,
    input  wire logic [sdmg_pkg::SPD_W-1:0]  steps_per_degree,
    input  wire logic                        q_not_empty,
    input  wire sdmg_pkg::cmd_t              q_head,
    output logic                             q_pop,
    output sdmg_pkg::seq_status_t            status_next
);

    logic                          moving_reg, moving_next;
    logic                          pulse_reg, pulse_next;
    logic                          sign_reg, sign_next;
    logic [sdmg_pkg::HP_W-1:0]     timer_reg, timer_next;
    logic [sdmg_pkg::HP_W-1:0]     hp_reg, hp_next;
    logic [sdmg_pkg::ANGLE_W-1:0]  angle_reg, angle_next;
    logic                          dir_reg, dir_next;
    logic [sdmg_pkg::PULSE_W-1:0]  left_reg, left_next;
    logic [sdmg_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [31:0]                   started_reg, started_next;

    logic                          launch;
    logic                          cnt_valid;
    logic [sdmg_pkg::PULSE_W-1:0]  cnt;
    logic                          zero_move;
    logic [13:0]                   small_prod;
    logic                          finish;
    logic [sdmg_pkg::ANGLE_W-1:0]  fin_angle;
    logic                          fin_dir;
    logic [sdmg_pkg::HP_W-1:0]     timer_dec;
    logic [sdmg_pkg::PULSE_W-1:0]  left_dec;

    sdmg_pulse_count u_count (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .launch           (launch),
        .angle            (q_head.angle),
        .steps_per_degree (steps_per_degree),
        .count_valid      (cnt_valid),
        .count            (cnt)
    );

    // Count is zero when a factor is zero, or when both factors are below 100
    // and so is their product
    assign small_prod = 14'(q_head.angle[6:0]) * 14'(steps_per_degree[6:0]);
    assign zero_move  = (q_head.angle == '0) || (steps_per_degree == '0)
                     || ((q_head.angle < sdmg_pkg::ANGLE_W'(sdmg_pkg::SMALL_LIMIT))
                         && (steps_per_degree < sdmg_pkg::SPD_W'(sdmg_pkg::SMALL_LIMIT))
                         && (small_prod < 14'(sdmg_pkg::SMALL_LIMIT)));

    assign timer_dec = timer_reg - 1'b1;
    assign left_dec  = left_reg - 1'b1;

    always_comb begin
        moving_next  = moving_reg;
        pulse_next   = pulse_reg;
        sign_next    = sign_reg;
        timer_next   = timer_reg;
        hp_next      = hp_reg;
        angle_next   = angle_reg;
        dir_next     = dir_reg;
        left_next    = left_reg;
        started_next = started_reg;
        q_pop        = 1'b0;
        launch       = 1'b0;
        finish       = 1'b0;
        fin_angle    = angle_reg;
        fin_dir      = dir_reg;

        // The count lands before the first low phase can end
        if (cnt_valid) begin
            left_next = cnt;
        end

        if (tick) begin
            if (!moving_reg) begin
                if (q_not_empty) begin
                    q_pop        = 1'b1;
                    started_next = started_reg + 1'b1;
                    angle_next   = q_head.angle;
                    dir_next     = q_head.dir;
                    hp_next      = q_head.half_period;
                    sign_next    = q_head.dir;
                    if (zero_move) begin
                        finish    = 1'b1;
                        fin_angle = q_head.angle;
                        fin_dir   = q_head.dir;
                    end else begin
                        launch      = 1'b1;
                        moving_next = 1'b1;
                        pulse_next  = 1'b1;
                        timer_next  = q_head.half_period;
                    end
                end
            end else if (timer_dec != '0) begin
                timer_next = timer_dec;
            end else if (pulse_reg) begin
                pulse_next = 1'b0;
                timer_next = hp_reg;
            end else if (left_dec == '0) begin
                finish = 1'b1;
            end else begin
                pulse_next = 1'b1;
                timer_next = hp_reg;
                left_next  = left_dec;
            end
        end

        if (finish) begin
            moving_next = 1'b0;
            pulse_next  = 1'b0;
            left_next   = '0;
            timer_next  = '0;
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (finish) begin
            if (fin_dir) begin
                pos_next = pos_reg + sdmg_pkg::POS_W'(fin_angle);
            end else begin
                pos_next = pos_reg - sdmg_pkg::POS_W'(fin_angle);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moving_reg  <= 1'b0;
            pulse_reg   <= 1'b0;
            sign_reg    <= 1'b0;
            timer_reg   <= '0;
            hp_reg      <= '0;
            angle_reg   <= '0;
            dir_reg     <= 1'b0;
            left_reg    <= '0;
            pos_reg     <= '0;
            started_reg <= '0;
        end else begin
            moving_reg  <= moving_next;
            pulse_reg   <= pulse_next;
            sign_reg    <= sign_next;
            timer_reg   <= timer_next;
            hp_reg      <= hp_next;
            angle_reg   <= angle_next;
            dir_reg     <= dir_next;
            left_reg    <= left_next;
            pos_reg     <= pos_next;
            started_reg <= started_next;
        end
    end

    assign status_next.pulse    = pulse_next;
    assign status_next.sign     = sign_next;
    assign status_next.busy     = moving_next;
    assign status_next.position = pos_next;
    assign status_next.started  = started_next;

    // A running move always has time left in its phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        moving_reg |-> (timer_reg != '0) && (timer_reg <= hp_reg))
        else $error("phase timer out of range during a move");

    // Step line is high only inside a move
    assert property (@(posedge aclk) disable iff (!aresetn)
        pulse_reg |-> moving_reg)
        else $error("step line high while idle");

    // No pulses owed once idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !moving_reg |-> (left_reg == '0))
        else $error("pulses left while idle");

    // The pulse count only arrives for a move that is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_valid |-> moving_reg)
        else $error("pulse count landed outside a move");

endmodule

`default_nettype wire

// ===== design/step_dir_move_generator_core.sv =====
// ----------------------------------------------------------------------------
// step_dir_move_generator_core : step/direction move generator
// Queues move commands, then on microsecond ticks replays them as step
// pulses with a direction level, tracking position and started moves.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+--------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata 40b command, s_tuser kind
//  m_       | out       | m_tvalid/m_tready  | m_tdata 72b status per item
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item is taken per clock; its result is in the output register on the
//  next clock. Throughput is set by the result register: a new item enters
//  whenever that register is empty or being drained.
//  A popped move has its pulse count ready in the next clock from the
//  two-stage multiply unit, before the count is first consumed.
//  Reset (aresetn low, synchronous) empties the queue and restores the
//  register defaults; no clearing pass is needed.
//  A stall on m_ holds the result and stops intake until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module step_dir_move_generator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Command / tick stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // header[7:0], angle_hundredths[23:8],
                                        // dir_byte[31:24], half_period[39:32]
    input  wire logic        s_tuser,   // func[0]
    // Status stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // pulse_level[0], sign_level[1], busy_res[2],
                                        // accepted[3], dropped[4],
                                        // position_hundredths[36:5],
                                        // moves_started[68:37], zero pad[71:69]
    // Register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [11:0] cfg_data
);

    // Configuration registers
    logic [sdmg_pkg::SPD_W-1:0] spd_reg;
    logic [sdmg_pkg::HP_W-1:0]  mhp_reg;

    // Result register
    logic        m_valid_reg;
    logic [71:0] m_data_reg;

    // Input field split
    logic                         in_accept;
    logic                         in_func;
    logic [7:0]                   in_header;
    logic [sdmg_pkg::ANGLE_W-1:0] in_angle;
    logic [7:0]                   in_dir;
    logic [sdmg_pkg::HP_W-1:0]    in_hp;

    logic                         cmd_valid;
    logic                         enq;
    logic                         drop;
    logic [sdmg_pkg::HP_W-1:0]    hp_clamped;
    sdmg_pkg::cmd_t               enq_cmd;
    sdmg_pkg::cmd_t               head_cmd;
    logic                         q_not_empty;
    logic                         q_full;
    logic                         q_pop;
    sdmg_pkg::seq_status_t        status_next;

    assign in_func   = s_tuser;
    assign in_header = s_tdata[7:0];
    assign in_angle  = s_tdata[23:8];
    assign in_dir    = s_tdata[31:24];
    assign in_hp     = s_tdata[39:32];

    // Take a new item whenever the result slot is free or draining
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // Registers are to be written only while idle (not enforced here), so always accept
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spd_reg <= sdmg_pkg::SPD_RESET;
            mhp_reg <= sdmg_pkg::MHP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sdmg_pkg::CFG_STEPS_PER_DEGREE: spd_reg <= cfg_data[sdmg_pkg::SPD_W-1:0];
                sdmg_pkg::CFG_MIN_HALF_PERIOD:  mhp_reg <= cfg_data[sdmg_pkg::HP_W-1:0];
                default: ;
            endcase
        end
    end

    // Raise the half-period to the floor, never below one tick
    always_comb begin
        hp_clamped = (in_hp < mhp_reg) ? mhp_reg : in_hp;
        if (hp_clamped == '0) begin
            hp_clamped = sdmg_pkg::HP_W'(1);
        end
    end

    assign cmd_valid = in_accept && (in_func == sdmg_pkg::FUNC_CMD)
                    && (in_header == sdmg_pkg::HEADER_CMD);
    assign enq  = cmd_valid && !q_full;
    assign drop = cmd_valid && q_full;

    assign enq_cmd.half_period = hp_clamped;
    assign enq_cmd.dir         = in_dir[0];
    assign enq_cmd.angle       = in_angle;

    sdmg_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (enq),
        .wr_data   (enq_cmd),
        .rd_en     (q_pop),
        .head_data (head_cmd),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    sdmg_step_seq u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick             (in_accept && (in_func == sdmg_pkg::FUNC_TICK)),
        .steps_per_degree (spd_reg),
        .q_not_empty      (q_not_empty),
        .q_head           (head_cmd),
        .q_pop            (q_pop),
        .status_next      (status_next)
    );

    // Hold the result until taken; load a fresh one on every accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= {3'b000,
                           status_next.started,
                           status_next.position,
                           drop,
                           enq,
                           status_next.busy,
                           status_next.sign,
                           status_next.pulse};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire
